// File: rtl/vwcg_pkg.sv
// Shared constants, types and tables for the VR180 warp coordinate generator.
// No dependencies; every other file refers to this package by scoped names.
package vwcg_pkg;

    localparam int VIEW_COLS    = 2048;
    localparam int VIEW_ROWS    = 2048;

    localparam int PIX_W        = 11;
    localparam int CAM_W        = 14;
    localparam int CTR_W        = 22;
    localparam int FOC_W        = 24;
    localparam int SPAN_W       = 17;
    localparam int COORD_W      = 21;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam int ANG_W        = 18;   // Q2.16 signed angle
    localparam int ZW           = 34;   // CORDIC datapath width
    localparam int TRIG_W       = 32;   // Q2.30 sin / cos
    localparam int NUM_W        = 57;   // focal * direction
    localparam int DEN_W        = 31;   // dir_z when in front
    localparam int REM_W        = 58;
    localparam int QB           = 23;   // quotient bits kept
    localparam int QUOT_W       = QB + 1;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [TRIG_W-1:0] DIRZ_MIN = 32'sd1073;
    localparam logic signed [25:0] OUT_MAX       = 26'sd2097151;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_WIDTH    = 3'd0,
        CFG_CAMERA_HEIGHT   = 3'd1,
        CFG_CENTER_X        = 3'd2,
        CFG_CENTER_Y        = 3'd3,
        CFG_FOCAL_LENGTH    = 3'd4,
        CFG_YAW_HALF_SPAN   = 3'd5,
        CFG_PITCH_HALF_SPAN = 3'd6
    } t_cfg_idx;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        unique case (i)
            0:  a = 34'sh3243F6A8;
            1:  a = 34'sh1DAC6705;
            2:  a = 34'sh0FADBAFC;
            3:  a = 34'sh07F56EA6;
            4:  a = 34'sh03FEAB76;
            5:  a = 34'sh01FFD55B;
            6:  a = 34'sh00FFFAAA;
            7:  a = 34'sh007FFF55;
            8:  a = 34'sh003FFFEA;
            9:  a = 34'sh001FFFFD;
            10: a = 34'sh000FFFFF;
            11: a = 34'sh0007FFFF;
            12: a = 34'sh0003FFFF;
            13: a = 34'sh0001FFFF;
            14: a = 34'sh0000FFFF;
            15: a = 34'sh00007FFF;
            16: a = 34'sh00003FFF;
            17: a = 34'sh00001FFF;
            18: a = 34'sh00000FFF;
            19: a = 34'sh000007FF;
            20: a = 34'sh000003FF;
            21: a = 34'sh000001FF;
            22: a = 34'sh000000FF;
            23: a = 34'sh0000007F;
            24: a = 34'sh0000003F;
            25: a = 34'sh0000001F;
            26: a = 34'sh0000000F;
            27: a = 34'sh00000008;
            28: a = 34'sh00000004;
            29: a = 34'sh00000002;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/vwcg_if.sv
// Valid/ready channel interfaces for pixel words in and map words out.
// Depends on vwcg_pkg for field widths.
interface vwcg_pix_if;
    logic                           valid;
    logic                           ready;
    logic [vwcg_pkg::PIX_W-1:0]     out_x;
    logic [vwcg_pkg::PIX_W-1:0]     out_y;
    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface vwcg_map_if;
    logic                           valid;
    logic                           ready;
    logic [vwcg_pkg::COORD_W-1:0]   src_u;
    logic [vwcg_pkg::COORD_W-1:0]   src_v;
    logic                           coord_valid;
    modport source (output valid, output src_u, output src_v, output coord_valid, input ready);
    modport sink   (input valid, input src_u, input src_v, input coord_valid, output ready);
endinterface

// File: rtl/vr180_warp_coordinate_generator.sv
// Top level: configuration registers, angle and projection stages around two
// CORDIC and two divider pipelines. Depends on vwcg_pkg, vwcg_if, vwcg_cordic, vwcg_divider.
//
// Maps each output-eye pixel (out_x, out_y) of a VR180 equirectangular view to
// a source camera coordinate (src_u, src_v) in Q13.8 with a valid flag. The
// block is a fully pipelined datapath built around the 30-stage CORDIC and the
// 23-stage quotient pipeline: while the output is not stalled it takes one
// word per clock and gives one word per clock. A stall on the output holds the
// whole pipeline; nothing is dropped. Configuration writes take effect for
// words accepted after the pipeline has drained.
module vr180_warp_coordinate_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vwcg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vwcg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    vwcg_pix_if.sink                            i_pix,
    vwcg_map_if.source                          o_map
);
    logic [vwcg_pkg::CAM_W-1:0]         r_cam_w, r_cam_h;
    logic signed [vwcg_pkg::CTR_W-1:0]  r_ctr_x, r_ctr_y;
    logic [vwcg_pkg::FOC_W-1:0]         r_focal;
    logic [vwcg_pkg::SPAN_W-1:0]        r_yaw_span, r_pitch_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_w      <= 14'd1920;
            r_cam_h      <= 14'd1080;
            r_ctr_x      <= -22'sd256;
            r_ctr_y      <= -22'sd256;
            r_focal      <= 24'd245760;
            r_yaw_span   <= 17'd102944;
            r_pitch_span <= 17'd102944;
        end else if (i_cfg_we) begin
            unique case (vwcg_pkg::t_cfg_idx'(i_cfg_idx))
                vwcg_pkg::CFG_CAMERA_WIDTH:    r_cam_w      <= i_cfg_data[vwcg_pkg::CAM_W-1:0];
                vwcg_pkg::CFG_CAMERA_HEIGHT:   r_cam_h      <= i_cfg_data[vwcg_pkg::CAM_W-1:0];
                vwcg_pkg::CFG_CENTER_X:        r_ctr_x      <= $signed(i_cfg_data[vwcg_pkg::CTR_W-1:0]);
                vwcg_pkg::CFG_CENTER_Y:        r_ctr_y      <= $signed(i_cfg_data[vwcg_pkg::CTR_W-1:0]);
                vwcg_pkg::CFG_FOCAL_LENGTH:    r_focal      <= i_cfg_data[vwcg_pkg::FOC_W-1:0];
                vwcg_pkg::CFG_YAW_HALF_SPAN:   r_yaw_span   <= i_cfg_data[vwcg_pkg::SPAN_W-1:0];
                vwcg_pkg::CFG_PITCH_HALF_SPAN: r_pitch_span <= i_cfg_data[vwcg_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic r_ov;
    logic en;
    assign en          = ~r_ov | o_map.ready;
    assign i_pix.ready = en;

    // angle stage 1: signed pixel offset times span
    logic signed [15:0] dx_pix, dy_pix;
    logic               eye_ok;
    logic signed [33:0] r_num_x, r_num_y;
    logic               r_a1_v, r_a1_ok;

    always_comb begin
        dx_pix = $signed(16'({i_pix.out_x, 1'b1})) - 16'(vwcg_pkg::VIEW_COLS);
        dy_pix = $signed(16'({i_pix.out_y, 1'b1})) - 16'(vwcg_pkg::VIEW_ROWS);
        eye_ok = (32'(i_pix.out_x) < vwcg_pkg::VIEW_COLS) &&
                 (32'(i_pix.out_y) < vwcg_pkg::VIEW_ROWS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x <= dx_pix * $signed({1'b0, r_yaw_span});
            r_num_y <= dy_pix * $signed({1'b0, r_pitch_span});
            r_a1_ok <= eye_ok;
        end
    end

    // angle stage 2: round to Q2.16
    logic [33:0] mag_x, mag_y, qa_x, qa_y;
    logic signed [vwcg_pkg::ANG_W-1:0] ang_x, ang_y;
    logic signed [vwcg_pkg::ANG_W-1:0] r_ang_x, r_ang_y;
    logic r_a2_v, r_a2_ok;

    always_comb begin
        mag_x = r_num_x[33] ? 34'(-r_num_x) : 34'(r_num_x);
        mag_y = r_num_y[33] ? 34'(-r_num_y) : 34'(r_num_y);
        qa_x  = (mag_x + 34'(vwcg_pkg::VIEW_COLS / 2)) / vwcg_pkg::VIEW_COLS;
        qa_y  = (mag_y + 34'(vwcg_pkg::VIEW_ROWS / 2)) / vwcg_pkg::VIEW_ROWS;
        ang_x = r_num_x[33] ? -$signed(qa_x[vwcg_pkg::ANG_W-1:0])
                            : $signed(qa_x[vwcg_pkg::ANG_W-1:0]);
        ang_y = r_num_y[33] ? -$signed(qa_y[vwcg_pkg::ANG_W-1:0])
                            : $signed(qa_y[vwcg_pkg::ANG_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_x <= ang_x;
            r_ang_y <= ang_y;
            r_a2_ok <= r_a1_ok;
        end
    end

    // sin / cos
    logic c_v, c_ok, c_pv, c_pok;
    logic signed [vwcg_pkg::TRIG_W-1:0] st, ct, sp, cp;

    vwcg_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a2_v),
        .i_flag  (r_a2_ok),
        .i_ang   (r_ang_x),
        .o_valid (c_v),
        .o_flag  (c_ok),
        .o_sin   (st),
        .o_cos   (ct)
    );

    vwcg_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a2_v),
        .i_flag  (r_a2_ok),
        .i_ang   (r_ang_y),
        .o_valid (c_pv),
        .o_flag  (c_pok),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    // direction products
    logic signed [63:0] r_px, r_pz;
    logic signed [vwcg_pkg::TRIG_W-1:0] r_m1_dy;
    logic r_m1_v, r_m1_ok;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px    <= cp * st;
            r_pz    <= cp * ct;
            r_m1_dy <= sp;
            r_m1_ok <= c_ok & c_pok;
        end
    end

    // focal times direction, split in 16-bit halves
    logic signed [vwcg_pkg::TRIG_W-1:0] dx, dz;
    logic signed [24:0] foc_s;
    logic signed [41:0] r_plo_x, r_plo_y;
    logic signed [40:0] r_phi_x, r_phi_y;
    logic signed [vwcg_pkg::TRIG_W-1:0] r_m2_dz;
    logic r_m2_v, r_m2_ok;

    always_comb begin
        dx    = r_px[61:30];
        dz    = r_pz[61:30];
        foc_s = $signed({1'b0, r_focal});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plo_x <= foc_s * $signed({1'b0, dx[15:0]});
            r_plo_y <= foc_s * $signed({1'b0, r_m1_dy[15:0]});
            r_phi_x <= foc_s * $signed(dx[31:16]);
            r_phi_y <= foc_s * $signed(r_m1_dy[31:16]);
            r_m2_dz <= dz;
            r_m2_ok <= r_m1_ok & (dz > vwcg_pkg::DIRZ_MIN);
        end
    end

    logic signed [vwcg_pkg::NUM_W-1:0] r_nx, r_ny;
    logic [vwcg_pkg::DEN_W-1:0]        r_den;
    logic r_m3_v, r_m3_ok;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx    <= ($signed(vwcg_pkg::NUM_W'(r_phi_x)) <<< 16) + vwcg_pkg::NUM_W'(r_plo_x);
            r_ny    <= ($signed(vwcg_pkg::NUM_W'(r_phi_y)) <<< 16) + vwcg_pkg::NUM_W'(r_plo_y);
            r_den   <= r_m2_dz[vwcg_pkg::DEN_W-1:0];
            r_m3_ok <= r_m2_ok;
        end
    end

    // projection quotients
    logic d_v, d_ok, d_vv, d_vok;
    logic signed [vwcg_pkg::QUOT_W-1:0] qu, qv;

    vwcg_divider u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_v),
        .i_ok    (r_m3_ok),
        .i_num   (r_nx),
        .i_den   (r_den),
        .o_valid (d_v),
        .o_ok    (d_ok),
        .o_quot  (qu)
    );

    vwcg_divider u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_v),
        .i_ok    (r_m3_ok),
        .i_num   (r_ny),
        .i_den   (r_den),
        .o_valid (d_vv),
        .o_ok    (d_vok),
        .o_quot  (qv)
    );

    // principal point, frame check, output word
    logic signed [25:0] cx, cy, u, v, umax, vmax, uraw, vraw;
    logic               hit;
    logic [vwcg_pkg::COORD_W-1:0] r_u, r_v;
    logic               r_hit;

    always_comb begin
        cx   = r_ctr_x[vwcg_pkg::CTR_W-1] ? $signed(26'(r_cam_w) << 7) : 26'(r_ctr_x);
        cy   = r_ctr_y[vwcg_pkg::CTR_W-1] ? $signed(26'(r_cam_h) << 7) : 26'(r_ctr_y);
        u    = 26'(qu) + cx;
        v    = 26'(qv) + cy;
        uraw = (26'(r_cam_w) - 26'sd1) <<< 8;
        vraw = (26'(r_cam_h) - 26'sd1) <<< 8;
        umax = (uraw > vwcg_pkg::OUT_MAX) ? vwcg_pkg::OUT_MAX : uraw;
        vmax = (vraw > vwcg_pkg::OUT_MAX) ? vwcg_pkg::OUT_MAX : vraw;
        hit  = d_ok & d_vok & (u >= 0) & (u <= umax) & (v >= 0) & (v <= vmax);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u   <= hit ? u[vwcg_pkg::COORD_W-1:0] : '0;
            r_v   <= hit ? v[vwcg_pkg::COORD_W-1:0] : '0;
            r_hit <= hit;
        end
    end

    // word valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_a1_v <= i_pix.valid;
            r_a2_v <= r_a1_v;
            r_m1_v <= c_v & c_pv;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_ov   <= d_v & d_vv;
        end
    end

    assign o_map.valid       = r_ov;
    assign o_map.src_u       = r_u;
    assign o_map.src_v       = r_v;
    assign o_map.coord_valid = r_hit;

endmodule

// File: rtl/vwcg_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage, Q2.16 angle in,
// Q2.30 sin/cos out. Depends on vwcg_pkg.
module vwcg_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_flag,
    input  logic signed [vwcg_pkg::ANG_W-1:0]   i_ang,
    output logic                                o_valid,
    output logic                                o_flag,
    output logic signed [vwcg_pkg::TRIG_W-1:0]  o_sin,
    output logic signed [vwcg_pkg::TRIG_W-1:0]  o_cos
);
    localparam int N = vwcg_pkg::CORDIC_STEPS;

    logic signed [vwcg_pkg::ZW-1:0] r_x [0:N];
    logic signed [vwcg_pkg::ZW-1:0] r_y [0:N];
    logic signed [vwcg_pkg::ZW-1:0] r_z [0:N];
    logic        [N:0]              r_flip;
    logic        [N:0]              r_flag;
    logic        [N:0]              r_v;
    logic                           r_ov;
    logic                           r_of;
    logic signed [vwcg_pkg::TRIG_W-1:0] r_sin, r_cos;

    logic signed [vwcg_pkg::ZW-1:0] z_in, n_z0;
    logic                           n_flip0;
    logic signed [vwcg_pkg::ZW-1:0] neg_x, neg_y;

    always_comb begin
        z_in = {{(vwcg_pkg::ZW - vwcg_pkg::ANG_W - 14){i_ang[vwcg_pkg::ANG_W-1]}}, i_ang, 14'd0};
        priority if (z_in > vwcg_pkg::HALF_PI_Q30) begin
            n_z0    = z_in - vwcg_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else if (z_in < -vwcg_pkg::HALF_PI_Q30) begin
            n_z0    = z_in + vwcg_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else begin
            n_z0    = z_in;
            n_flip0 = 1'b0;
        end
        neg_x = -r_x[N];
        neg_y = -r_y[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= vwcg_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            r_flag[0] <= i_flag;
            for (int i = 0; i < N; i++) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - vwcg_pkg::atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + vwcg_pkg::atan_q30(i);
                end
                r_flip[i+1] <= r_flip[i];
                r_flag[i+1] <= r_flag[i];
            end
            r_sin <= r_flip[N] ? neg_y[vwcg_pkg::TRIG_W-1:0] : r_y[N][vwcg_pkg::TRIG_W-1:0];
            r_cos <= r_flip[N] ? neg_x[vwcg_pkg::TRIG_W-1:0] : r_x[N][vwcg_pkg::TRIG_W-1:0];
            r_of  <= r_flag[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_ov <= r_v[N];
        end
    end

    assign o_valid = r_ov;
    assign o_flag  = r_of;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// File: rtl/vwcg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, rounding half away
// from zero; flags quotients too large for QB bits. Depends on vwcg_pkg.
module vwcg_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_ok,
    input  logic signed [vwcg_pkg::NUM_W-1:0]   i_num,
    input  logic        [vwcg_pkg::DEN_W-1:0]   i_den,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic signed [vwcg_pkg::QUOT_W-1:0]  o_quot
);
    localparam int Q  = vwcg_pkg::QB;
    localparam int NS = Q + 2;

    logic [vwcg_pkg::REM_W-1:0] r_rem [0:NS-1];
    logic [vwcg_pkg::DEN_W-1:0] r_den [0:NS-1];
    logic [Q-1:0]               r_q   [0:NS-1];
    logic [NS-1:0]              r_neg;
    logic [NS-1:0]              r_ok;
    logic [NS-1:0]              r_v;
    logic                       r_ov, r_ook;
    logic signed [vwcg_pkg::QUOT_W-1:0] r_quot;

    logic [vwcg_pkg::NUM_W-1:0] mag;
    logic [vwcg_pkg::REM_W-1:0] lim;
    logic                       ovf;
    logic signed [vwcg_pkg::QUOT_W-1:0] qpos;

    always_comb begin
        mag  = i_num[vwcg_pkg::NUM_W-1] ? vwcg_pkg::NUM_W'(-i_num) : vwcg_pkg::NUM_W'(i_num);
        lim  = vwcg_pkg::REM_W'(r_den[0]) << Q;
        ovf  = r_rem[0] >= lim;
        qpos = $signed({1'b0, r_q[NS-1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= vwcg_pkg::REM_W'(mag) + vwcg_pkg::REM_W'(i_den >> 1);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[vwcg_pkg::NUM_W-1];
            r_ok[0]  <= i_ok;
            r_rem[1] <= r_rem[0];
            r_den[1] <= r_den[0];
            r_q[1]   <= '0;
            r_neg[1] <= r_neg[0];
            r_ok[1]  <= r_ok[0] & ~ovf;
            r_quot   <= r_neg[NS-1] ? -qpos : qpos;
            r_ook    <= r_ok[NS-1];
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_bit
        localparam int B = Q - 1 - k;
        logic [vwcg_pkg::REM_W-1:0] dsh;
        logic                       take;
        always_comb begin
            dsh  = vwcg_pkg::REM_W'(r_den[k+1]) << B;
            take = r_rem[k+1] >= dsh;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+2]    <= take ? r_rem[k+1] - dsh : r_rem[k+1];
                r_q[k+2]      <= r_q[k+1] | (Q'(take) << B);
                r_den[k+2]    <= r_den[k+1];
                r_neg[k+2]    <= r_neg[k+1];
                r_ok[k+2]     <= r_ok[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_ok    = r_ook;
    assign o_quot  = r_quot;

endmodule
